FILE: sv/pbsr_pkg.sv
// package: shared types and constants for the packed bitmap to rectangle decoder
`timescale 1ns / 1ps
`default_nettype none
package pbsr_pkg;

	localparam int GRID_SIDE = 16;

	localparam int IDX_W   = 6;
	localparam int VAL_W   = 8;
	localparam int COORD_W = 8;
	localparam int MASK_W  = 7;
	localparam int COL_W   = 5;
	localparam int ROW_W   = 4;

	localparam int FIFO_DEPTH_DEF = 4;

	// register indexes
	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [7:0] RST_WIDTH  = 8'd128;
	localparam logic [7:0] RST_HEIGHT = 8'd64;
	localparam logic [7:0] BIG_HEIGHT = 8'd64;

	// scale factors
	localparam int SX_BIG   = 8;
	localparam int SY_BIG   = 4;
	localparam int SX_SMALL = 4;
	localparam int SY_SMALL = 2;

	localparam logic [9:0] SPAN_X_BIG   = 10'(GRID_SIDE * SX_BIG);
	localparam logic [9:0] SPAN_X_SMALL = 10'(GRID_SIDE * SX_SMALL);
	localparam logic [9:0] SPAN_Y_BIG   = 10'(GRID_SIDE * SY_BIG);
	localparam logic [9:0] SPAN_Y_SMALL = 10'(GRID_SIDE * SY_SMALL);

	// format geometry
	localparam logic [2:0] HEAD_PIX_A = 3'd5;
	localparam logic [2:0] TAIL_PIX_A = 3'd1;
	localparam logic [2:0] HEAD_PIX_B = 3'd7;
	localparam logic [2:0] TAIL_PIX_B = 3'd2;
	localparam logic [IDX_W-1:0] HEAD_LEN_A  = 6'd48;
	localparam logic [IDX_W-1:0] HEAD_LEN_B  = 6'd32;
	localparam logic [IDX_W-1:0] TOTAL_LEN_B = 6'd48;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [COL_W-1:0]  col0;
		logic [ROW_W-1:0]  row;
	} entry_t;

	typedef struct packed {
		logic               big_scale;
		logic [COORD_W-1:0] offx;
		logic [COORD_W-1:0] offy;
	} geom_t;

endpackage
`default_nettype wire

FILE: sv/pbsr_front.sv
// front end: classifies a bitmap byte into a pixel mask, column and row
`timescale 1ns / 1ps
`default_nettype none
module pbsr_front (
	input  wire logic                     fmt,
	input  wire logic [pbsr_pkg::IDX_W-1:0] byte_index,
	input  wire logic [pbsr_pkg::VAL_W-1:0] byte_value,
	output pbsr_pkg::entry_t              entry,
	output logic                          has_pixels
);

	logic       in_range;
	logic       is_head;
	logic [2:0] head_pix;
	logic [2:0] npix;
	logic [2:0] hp_m1;
	logic [pbsr_pkg::MASK_W-1:0] mask;

	always_comb begin
		if (!fmt) begin
			in_range = 1'b1;
			is_head  = byte_index < pbsr_pkg::HEAD_LEN_A;
			head_pix = pbsr_pkg::HEAD_PIX_A;
			npix     = is_head ? pbsr_pkg::HEAD_PIX_A : pbsr_pkg::TAIL_PIX_A;
		end else begin
			in_range = byte_index < pbsr_pkg::TOTAL_LEN_B;
			is_head  = byte_index < pbsr_pkg::HEAD_LEN_B;
			head_pix = pbsr_pkg::HEAD_PIX_B;
			npix     = is_head ? pbsr_pkg::HEAD_PIX_B : pbsr_pkg::TAIL_PIX_B;
		end
		hp_m1 = head_pix - 3'd1;
	end

	// pixel p is bit (head_pix - 1 - p), leftmost pixel first
	always_comb begin
		mask = '0;
		for (int p = 0; p < pbsr_pkg::MASK_W; p++) begin
			if (3'(p) < npix) begin
				mask[p] = in_range & byte_value[hp_m1 - 3'(p)];
			end
		end
	end

	assign entry.mask = mask;
	assign entry.col0 = pbsr_pkg::COL_W'(byte_index[5:4]) * pbsr_pkg::COL_W'(head_pix);
	assign entry.row  = byte_index[3:0];
	assign has_pixels = |mask;

endmodule
`default_nettype wire

FILE: sv/pbsr_fifo.sv
// fifo: short queue of classified bytes between front and back
`timescale 1ns / 1ps
`default_nettype none
module pbsr_fifo #(
	parameter int DEPTH = pbsr_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire pbsr_pkg::entry_t push_data,
	input  wire logic             pop,
	output pbsr_pkg::entry_t      head,
	output logic                  not_empty,
	output logic                  not_full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	pbsr_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign not_empty = count_q != '0;
	assign not_full  = count_q != FULL_CNT;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/pbsr_back.sv
// back end: walks the set pixels of each byte and emits one rectangle per cycle while the output is not stalled
`timescale 1ns / 1ps
`default_nettype none
module pbsr_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pbsr_pkg::geom_t             geom,
	input  wire pbsr_pkg::entry_t            head,
	input  wire logic                        head_valid,
	output logic                             pop,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [4*pbsr_pkg::COORD_W-1:0]   m_tdata,
	output logic                             m_tlast
);

	logic                        busy_q;
	pbsr_pkg::entry_t            cur_q;
	pbsr_pkg::entry_t            cur;
	logic                        cur_valid;
	logic                        advance;
	logic [2:0]                  pix;
	logic [pbsr_pkg::MASK_W-1:0] rest;
	logic [pbsr_pkg::COL_W-1:0]  colp;
	logic [7:0]                  x;
	logic [7:0]                  y;
	logic [7:0]                  xr;
	logic [7:0]                  yb;
	logic                        out_valid_q;
	logic [4*pbsr_pkg::COORD_W-1:0] out_data_q;
	logic                        out_last_q;

	assign cur       = busy_q ? cur_q : head;
	assign cur_valid = busy_q | head_valid;
	assign advance   = cur_valid && (!out_valid_q || m_tready);
	assign pop       = advance && !busy_q;

	// lowest set pixel is the leftmost remaining one
	always_comb begin
		pix = 3'd0;
		for (int p = pbsr_pkg::MASK_W - 1; p >= 0; p--) begin
			if (cur.mask[p]) begin
				pix = 3'(p);
			end
		end
		rest      = cur.mask;
		rest[pix] = 1'b0;
	end

	always_comb begin
		colp = cur.col0 + pbsr_pkg::COL_W'(pix);
		if (geom.big_scale) begin
			x  = geom.offx + 8'({colp, 3'b000});
			y  = geom.offy + 8'({cur.row, 2'b00});
			xr = x + 8'(pbsr_pkg::SX_BIG - 1);
			yb = y + 8'(pbsr_pkg::SY_BIG - 1);
		end else begin
			x  = geom.offx + 8'({colp, 2'b00});
			y  = geom.offy + 8'({cur.row, 1'b0});
			xr = x + 8'(pbsr_pkg::SX_SMALL - 1);
			yb = y + 8'(pbsr_pkg::SY_SMALL - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				busy_q <= rest != '0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cur_q.mask <= rest;
			cur_q.col0 <= cur.col0;
			cur_q.row  <= cur.row;
			out_data_q <= {yb, xr, y, x};
			out_last_q <= rest == '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

FILE: sv/packed_bitmap_to_scaled_rects.sv
// top level: packed 16x16 bitmap byte to scaled, centered filled rectangles
`timescale 1ns / 1ps
`default_nettype none
// Each input beat is one byte of a packed 16x16 monochrome bitmap; the block
// emits one rectangle beat per set pixel, leftmost first, with tlast on the
// final one, and nothing for a byte with no used bit set or beyond the format.
// The front end classifies a byte in the cycle it arrives and places it in a
// FIFO_DEPTH-entry queue; the back end sends one rectangle per cycle while the
// output is not stalled; n set pixels give n beats (at most 7). Input beats
// are taken every cycle while the queue has room, even while the output stalls.
// Write configuration only while the block is idle.
module packed_bitmap_to_scaled_rects #(
	parameter int FIFO_DEPTH = pbsr_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // byte_index[5:0], byte_value[13:6], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // rect_left, rect_top, rect_right, rect_bottom
	output logic             m_tlast
);

	logic             fmt_q;
	logic [7:0]       width_q;
	logic [7:0]       height_q;
	pbsr_pkg::geom_t  geom;
	logic [9:0]       diffx;
	logic [9:0]       diffy;
	pbsr_pkg::entry_t fr_entry;
	logic             fr_has_pix;
	pbsr_pkg::entry_t q_head;
	logic             q_not_empty;
	logic             q_not_full;
	logic             q_push;
	logic             q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= 1'b0;
			width_q  <= pbsr_pkg::RST_WIDTH;
			height_q <= pbsr_pkg::RST_HEIGHT;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				pbsr_pkg::REG_FORMAT: fmt_q    <= cfg_wdata[0];
				pbsr_pkg::REG_WIDTH:  width_q  <= cfg_wdata;
				pbsr_pkg::REG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// floor of half the difference, wrapped to 8 bits
	always_comb begin
		geom.big_scale = height_q == pbsr_pkg::BIG_HEIGHT;
		diffx = {2'b00, width_q} -
			(geom.big_scale ? pbsr_pkg::SPAN_X_BIG : pbsr_pkg::SPAN_X_SMALL);
		diffy = {2'b00, height_q} -
			(geom.big_scale ? pbsr_pkg::SPAN_Y_BIG : pbsr_pkg::SPAN_Y_SMALL);
		geom.offx = diffx[8:1];
		geom.offy = diffy[8:1];
	end

	pbsr_front u_front (
		.fmt        (fmt_q),
		.byte_index (s_tdata[5:0]),
		.byte_value (s_tdata[13:6]),
		.entry      (fr_entry),
		.has_pixels (fr_has_pix)
	);

	assign s_tready = q_not_full;
	assign q_push   = s_tvalid && s_tready && fr_has_pix;

	pbsr_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (fr_entry),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_not_empty),
		.not_full  (q_not_full)
	);

	pbsr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom),
		.head       (q_head),
		.head_valid (q_not_empty),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

	a_rect_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (8'(m_tdata[23:16] - m_tdata[7:0]) ==
			(geom.big_scale ? 8'(pbsr_pkg::SX_BIG - 1) : 8'(pbsr_pkg::SX_SMALL - 1))))
		else $error("rectangle width does not match scale");

	a_rect_height: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (8'(m_tdata[31:24] - m_tdata[15:8]) ==
			(geom.big_scale ? 8'(pbsr_pkg::SY_BIG - 1) : 8'(pbsr_pkg::SY_SMALL - 1))))
		else $error("rectangle height does not match scale");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("queue popped while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_not_full)
		else $error("queue pushed while full");

endmodule
`default_nettype wire

FILE: test/tb.sv
// testbench for the packed bitmap to scaled rectangle decoder
`timescale 1ns / 1ps
module tb;

	localparam logic [1:0] REG_NONE = 2'd3;
	localparam bit FMT_FIVE  = 1'b0;
	localparam bit FMT_SEVEN = 1'b1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 16;
	localparam int BYTES_PER_PHASE = 40;
	localparam int PHASES = 8;

	typedef struct {
		logic [7:0] left;
		logic [7:0] top;
		logic [7:0] right;
		logic [7:0] bottom;
		logic       last;
	} rect_t;

	class rect_checker;
		bit         fmt;
		logic [7:0] width;
		logic [7:0] height;
		rect_t      rects_due[$];
		int         errors;

		function new();
			fmt = FMT_FIVE;
			width = pbsr_pkg::RST_WIDTH;
			height = pbsr_pkg::RST_HEIGHT;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] addr, logic [7:0] data);
			case (addr)
				pbsr_pkg::REG_FORMAT: fmt = data[0];
				pbsr_pkg::REG_WIDTH:  width = data;
				pbsr_pkg::REG_HEIGHT: height = data;
				default: ;
			endcase
		endfunction

		// floor((dim - span) / 2) wrapped to 8 bits
		function int unsigned centre(int unsigned dim, int unsigned span);
			return (((dim + 512 - span) >> 1) - 256) & 8'hFF;
		endfunction

		function void note_byte(logic [5:0] idx, logic [7:0] val);
			int unsigned head_len, head_pix, tail_pix, total_len, npix;
			int unsigned sx, sy, offx, offy, col0, row_n, x, y, count;
			rect_t r;
			if (fmt == FMT_FIVE) begin
				head_len = pbsr_pkg::HEAD_LEN_A; head_pix = pbsr_pkg::HEAD_PIX_A;
				tail_pix = pbsr_pkg::TAIL_PIX_A; total_len = 64;
			end else begin
				head_len = pbsr_pkg::HEAD_LEN_B; head_pix = pbsr_pkg::HEAD_PIX_B;
				tail_pix = pbsr_pkg::TAIL_PIX_B; total_len = pbsr_pkg::TOTAL_LEN_B;
			end
			if (idx >= total_len)
				return;
			npix = (idx < head_len) ? head_pix : tail_pix;
			sx = (height == pbsr_pkg::BIG_HEIGHT) ? pbsr_pkg::SX_BIG : pbsr_pkg::SX_SMALL;
			sy = (height == pbsr_pkg::BIG_HEIGHT) ? pbsr_pkg::SY_BIG : pbsr_pkg::SY_SMALL;
			offx = centre(width, pbsr_pkg::GRID_SIDE * sx);
			offy = centre(height, pbsr_pkg::GRID_SIDE * sy);
			col0 = (idx / pbsr_pkg::GRID_SIDE) * head_pix;
			row_n = idx % pbsr_pkg::GRID_SIDE;
			count = 0;
			for (int p = 0; p < npix; p++) begin
				if (val[head_pix - 1 - p]) begin
					x = (offx + (col0 + p) * sx) & 8'hFF;
					y = (offy + row_n * sy) & 8'hFF;
					r.left = x[7:0];
					r.top = y[7:0];
					r.right = 8'(x + sx - 1);
					r.bottom = 8'(y + sy - 1);
					r.last = 1'b0;
					rects_due.push_back(r);
					count++;
				end
			end
			if (count > 0) begin
				r = rects_due[rects_due.size() - 1];
				r.last = 1'b1;
				rects_due[rects_due.size() - 1] = r;
			end
		endfunction

		function void check_rect(logic [31:0] data, logic last);
			rect_t want;
			string names[5];
			logic [7:0] want_v[5];
			logic [7:0] got_v[5];
			if (rects_due.size() == 0) begin
				$error("rectangle beat with none due: tdata %h tlast %b", data, last);
				errors++;
				return;
			end
			want = rects_due.pop_front();
			names = '{"rect_left", "rect_top", "rect_right", "rect_bottom", "last_of_byte"};
			want_v = '{want.left, want.top, want.right, want.bottom, {7'd0, want.last}};
			got_v = '{data[7:0], data[15:8], data[23:16], data[31:24], {7'd0, last}};
			for (int f = 0; f < 5; f++) begin
				if (got_v[f] !== want_v[f]) begin
					$error("%s: expected %0d, actual %0d", names[f], want_v[f], got_v[f]);
					errors++;
				end
			end
		endfunction

		function int pending();
			return rects_due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_addr = pbsr_pkg::REG_FORMAT;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;

	int tx_idle_pct = 35;
	int rx_idle_pct = 69;
	int cycles = 0;
	rect_checker board;

	packed_bitmap_to_scaled_rects dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_rect(m_tdata, m_tlast);
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic send_byte(logic [5:0] idx, logic [7:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, val, idx};
		do @(posedge clk); while (!s_tready);
		board.note_byte(idx, val);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apply_setting(bit fmt, logic [7:0] w, logic [7:0] h, bit stray);
		logic [1:0] addrs[$];
		logic [7:0] vals[$];
		addrs = '{pbsr_pkg::REG_FORMAT, pbsr_pkg::REG_WIDTH, pbsr_pkg::REG_HEIGHT};
		vals = '{{7'($urandom), fmt}, w, h};
		if (stray) begin
			addrs.push_back(REG_NONE);
			vals.push_back(8'hA5);
		end
		foreach (addrs[i]) begin
			cfg_wen <= 1'b1;
			cfg_addr <= addrs[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
			board.set_reg(addrs[i], vals[i]);
		end
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		// {byte_index, byte_value}
		logic [13:0] five_bytes[$];
		logic [13:0] seven_bytes[$];
		bit          fmts[PHASES];
		logic [7:0]  widths[PHASES];
		logic [7:0]  heights[PHASES];
		logic [7:0]  v;
		five_bytes = '{{6'd0, 8'hFF}, {6'd0, 8'h00}, {6'd0, 8'hE0}, {6'd15, 8'h15},
			{6'd16, 8'h0A}, {6'd47, 8'h1F}, {6'd48, 8'h10}, {6'd48, 8'h0F},
			{6'd63, 8'hFF}, {6'd31, 8'h11}};
		seven_bytes = '{{6'd0, 8'h7F}, {6'd0, 8'h80}, {6'd31, 8'h55}, {6'd32, 8'h60},
			{6'd32, 8'h9F}, {6'd47, 8'hFF}, {6'd48, 8'hFF}, {6'd63, 8'hFF}};
		fmts = '{FMT_FIVE, FMT_SEVEN, FMT_FIVE, FMT_SEVEN,
			FMT_FIVE, FMT_SEVEN, FMT_FIVE, FMT_SEVEN};
		widths = '{8'd128, 8'd128, 8'd0, 8'd255, 8'd255, 8'd0, 8'd100, 8'd37};
		heights = '{8'd64, 8'd64, 8'd0, 8'd255, 8'd64, 8'd64, 8'd63, 8'd65};
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (five_bytes[i])
			send_byte(five_bytes[i][13:8], five_bytes[i][7:0]);
		drain();
		apply_setting(FMT_SEVEN, pbsr_pkg::RST_WIDTH, pbsr_pkg::RST_HEIGHT, 1'b0);
		foreach (seven_bytes[i])
			send_byte(seven_bytes[i][13:8], seven_bytes[i][7:0]);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 3) begin
				tx_idle_pct = 35; rx_idle_pct = 69;
			end else if (ph < 6) begin
				tx_idle_pct = 69; rx_idle_pct = 35;
			end else begin
				tx_idle_pct = 0; rx_idle_pct = 0;
			end
			apply_setting(fmts[ph], widths[ph], heights[ph], ph == 2);
			for (int n = 0; n < BYTES_PER_PHASE; n++) begin
				case ($urandom_range(9))
					0: v = 8'h00;
					1: v = 8'hFF;
					default: v = 8'($urandom_range(255));
				endcase
				send_byte(6'($urandom_range(63)), v);
			end
			drain();
		end

		if (board.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
